### hdl/tspt_pkg.sv
// ----------------------------------------------------------------------------
// tspt_pkg: shared types and constants of the timestamped pending table
// Request and response payloads, table entry layout, opcodes, status codes,
// sequencer states and the compare unit interface.
// ----------------------------------------------------------------------------
package tspt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int MAX_SWEEP_DEF   = 16;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_FIND  = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [19:0] key;
		logic [31:0] stamp_sec;
		logic [29:0] stamp_nsec;
		logic [4:0]  max_count;
	} req_t;

	typedef struct packed {
		logic        entry_valid;
		logic [19:0] out_key;
		logic [31:0] out_sec;
		logic [29:0] out_nsec;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [19:0] key;
		logic [31:0] sec;
		logic [29:0] nsec;
	} entry_t;

	typedef enum logic {
		CMP_KEY,
		CMP_STAMP
	} cmp_mode_t;

	typedef struct packed {
		cmp_mode_t mode;
		entry_t    probe;
	} cmp_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_SHIFT,
		S_SWEEP,
		S_SWEEP_END,
		S_DONE
	} state_t;

	function automatic rsp_t make_rsp(input logic valid, input entry_t e,
		input logic [1:0] status, input logic last);
		rsp_t r;
		r.entry_valid = valid;
		r.out_key     = valid ? e.key  : 20'd0;
		r.out_sec     = valid ? e.sec  : 32'd0;
		r.out_nsec    = valid ? e.nsec : 30'd0;
		r.status      = status;
		r.last        = last;
		return r;
	endfunction

endpackage

### hdl/tspt_ram.sv
// ----------------------------------------------------------------------------
// tspt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tspt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/tspt_cmp.sv
// ----------------------------------------------------------------------------
// tspt_cmp: shared compare unit
// Key equality for lookup, stamp at-or-before test for the expiry sweep.
// ----------------------------------------------------------------------------
module tspt_cmp (
	input  tspt_pkg::cmp_req_t query,
	input  tspt_pkg::entry_t   slot,
	output logic               hit
);
	import tspt_pkg::*;

	logic sec_lt;
	logic sec_eq;
	logic nsec_le;

	assign sec_lt  = slot.sec < query.probe.sec;
	assign sec_eq  = slot.sec == query.probe.sec;
	assign nsec_le = slot.nsec <= query.probe.nsec;

	always_comb begin
		case (query.mode)
			CMP_KEY:   hit = slot.key == query.probe.key;
			CMP_STAMP: hit = sec_lt || (sec_eq && nsec_le);
			default:   hit = 1'b0;
		endcase
	end

endmodule

### hdl/timestamped_pending_table.sv
// ----------------------------------------------------------------------------
// timestamped_pending_table: age-ordered table of pending requests
// Push, pop by key and expiry sweep over a RAM-backed table, one entry per
// cycle through a shared compare unit while the response channel does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one transaction at a time;
//   req_ready is high only while the sequencer is idle. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns results from an output register, so a
//   new request is taken while the previous result still waits.
//   Push: the result loads in S_DONE, once the output register is free.
//   Pop by key: entries are visited from newest to the match, then each
//   younger entry moves down one slot to close the gap, then S_DONE.
//   Sweep: all stored entries are walked oldest first through the single
//   RAM read port, then S_SWEEP_END and S_DONE. Opcode 3 is dropped with
//   no result.
//   Reset empties the table at once (occupancy cleared, no RAM pass) and
//   drops any pending result.
//   A stalled receiver holds rsp; the sequencer then waits before loading
//   the next result and a sweep pauses in place without losing its read.
// ----------------------------------------------------------------------------
module timestamped_pending_table #(
	parameter int TABLE_DEPTH = tspt_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_SWEEP   = tspt_pkg::MAX_SWEEP_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tspt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tspt_pkg::rsp_t rsp
);
	import tspt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = $clog2(MAX_SWEEP + 1);
	localparam int EW = $bits(entry_t);
	localparam logic [CW-1:0] FULL_OCC  = CW'(TABLE_DEPTH);
	localparam logic [SW-1:0] SWEEP_CAP = SW'(MAX_SWEEP);

	// sequencer and table bookkeeping
	state_t          state_q, state_d;
	logic [CW-1:0]   occ_q;
	logic [AW-1:0]   idx_q;
	logic [CW-1:0]   wr_q;
	logic [SW-1:0]   cnt_q;
	logic [SW-1:0]   limit_q;
	logic [1:0]      op_q;
	entry_t          qry_q;
	entry_t          hold_q;
	logic            hold_vld_q;
	rsp_t            fin_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	// RAM port and compare unit wiring
	logic [AW-1:0]   ram_raddr;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic [EW-1:0]   ram_rdata;
	entry_t          entry;
	cmp_req_t        cmp_req;
	logic            hit;

	logic            req_fire;
	logic            rsp_free;
	logic            take;
	logic            sweep_stall;
	logic            rsp_load;
	rsp_t            rsp_next;
	logic [CW:0]     idx_p1;
	logic [CW:0]     idx_p2;
	logic [CW:0]     occ_ext;
	logic            push_ok;
	logic [SW-1:0]   limit_in;

	tspt_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign entry   = entry_t'(ram_rdata);
	assign cmp_req = '{mode: ((op_q == OP_SWEEP) ? CMP_STAMP : CMP_KEY), probe: qry_q};

	tspt_cmp u_cmp (
		.query (cmp_req),
		.slot  (entry),
		.hit   (hit)
	);

	assign req_ready   = state_q == S_IDLE;
	assign req_fire    = req_valid && req_ready;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;
	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign idx_p1      = (CW + 1)'(idx_q) + (CW + 1)'(1);
	assign idx_p2      = (CW + 1)'(idx_q) + (CW + 1)'(2);
	assign occ_ext     = (CW + 1)'(occ_q);
	assign push_ok     = occ_q != FULL_OCC;
	// taken entries leave the table; the rest compact toward slot 0
	assign take        = (cnt_q < limit_q) && hit;
	// a second taken entry must flush the held one through rsp first
	assign sweep_stall = take && hold_vld_q && !rsp_free;
	assign limit_in    = (int'(req.max_count) > MAX_SWEEP) ? SWEEP_CAP
		: SW'(req.max_count);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (req.opcode)
						OP_PUSH:  state_d = S_DONE;
						OP_FIND:  state_d = (occ_q == '0) ? S_DONE : S_FIND;
						OP_SWEEP: state_d = (occ_q == '0) ? S_SWEEP_END : S_SWEEP;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_FIND: begin
				if (hit) begin
					state_d = (idx_p1 < occ_ext) ? S_SHIFT : S_DONE;
				end else if (idx_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				if (idx_p2 >= occ_ext) begin
					state_d = S_DONE;
				end
			end
			S_SWEEP: begin
				if (!sweep_stall && idx_p1 == occ_ext) begin
					state_d = S_SWEEP_END;
				end
			end
			S_SWEEP_END: state_d = S_DONE;
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM port and result register control
	always_comb begin
		ram_raddr = idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = entry;
		rsp_load  = 1'b0;
		rsp_next  = fin_q;
		case (state_q)
			S_IDLE: begin
				// start the first read of a lookup or sweep right away
				ram_raddr = (req.opcode == OP_SWEEP) ? '0 : AW'(occ_q - CW'(1));
				if (req_fire && req.opcode == OP_PUSH && push_ok) begin
					ram_we          = 1'b1;
					ram_waddr       = occ_q[AW-1:0];
					ram_wdata.key   = req.key;
					ram_wdata.sec   = req.stamp_sec;
					ram_wdata.nsec  = req.stamp_nsec;
				end
			end
			S_FIND: begin
				ram_raddr = hit ? idx_p1[AW-1:0] : idx_q - AW'(1);
			end
			S_SHIFT: begin
				// move the younger neighbor down one slot, fetch the next
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = entry;
				ram_raddr = idx_p2[AW-1:0];
			end
			S_SWEEP: begin
				ram_raddr = sweep_stall ? idx_q : idx_p1[AW-1:0];
				if (!take) begin
					ram_we    = 1'b1;
					ram_waddr = wr_q[AW-1:0];
					ram_wdata = entry;
				end
				if (take && hold_vld_q && rsp_free) begin
					rsp_load = 1'b1;
					rsp_next = make_rsp(1'b1, hold_q, STAT_OK, 1'b0);
				end
			end
			S_DONE: begin
				rsp_load = rsp_free;
				rsp_next = fin_q;
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			idx_q       <= '0;
			wr_q        <= '0;
			cnt_q       <= '0;
			limit_q     <= '0;
			op_q        <= OP_PUSH;
			qry_q       <= '0;
			hold_q      <= '0;
			hold_vld_q  <= 1'b0;
			fin_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q       <= req.opcode;
						qry_q.key  <= req.key;
						qry_q.sec  <= req.stamp_sec;
						qry_q.nsec <= req.stamp_nsec;
						limit_q    <= limit_in;
						cnt_q      <= '0;
						wr_q       <= '0;
						hold_vld_q <= 1'b0;
						idx_q      <= (req.opcode == OP_SWEEP) ? '0
							: AW'(occ_q - CW'(1));
						case (req.opcode)
							OP_PUSH: begin
								if (push_ok) begin
									occ_q <= occ_q + CW'(1);
									fin_q <= make_rsp(1'b0, '0, STAT_OK, 1'b1);
								end else begin
									fin_q <= make_rsp(1'b0, '0, STAT_FULL, 1'b1);
								end
							end
							OP_FIND: begin
								fin_q <= make_rsp(1'b0, '0, STAT_NOT_FOUND, 1'b1);
							end
							default: begin
								fin_q <= make_rsp(1'b0, '0, STAT_OK, 1'b1);
							end
						endcase
					end
				end
				S_FIND: begin
					if (hit) begin
						fin_q <= make_rsp(1'b1, entry, STAT_OK, 1'b1);
						if (idx_p1 >= occ_ext) begin
							occ_q <= occ_q - CW'(1);
						end
					end else if (idx_q != '0) begin
						idx_q <= idx_q - AW'(1);
					end
				end
				S_SHIFT: begin
					if (idx_p2 < occ_ext) begin
						idx_q <= idx_q + AW'(1);
					end else begin
						occ_q <= occ_q - CW'(1);
					end
				end
				S_SWEEP: begin
					if (!sweep_stall) begin
						idx_q <= idx_q + AW'(1);
						if (take) begin
							hold_q     <= entry;
							hold_vld_q <= 1'b1;
							cnt_q      <= cnt_q + SW'(1);
						end else begin
							wr_q <= wr_q + CW'(1);
						end
					end
				end
				S_SWEEP_END: begin
					occ_q <= wr_q;
					// the held entry is the youngest one taken: mark it last
					fin_q <= hold_vld_q ? make_rsp(1'b1, hold_q, STAT_OK, 1'b1)
						: make_rsp(1'b0, '0, STAT_OK, 1'b1);
				end
				default: begin
					occ_q <= occ_q;
				end
			endcase
			// output register: load a result, or drop it once taken
			if (rsp_load) begin
				rsp_q       <= rsp_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_OCC)
		else $error("occupancy above table depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || rsp_ready))
		else $error("result loaded over a pending result");

	a_sweep_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (cnt_q <= limit_q && wr_q <= CW'(idx_q)))
		else $error("sweep count or compaction pointer out of range");

	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.opcode == OP_PUSH && push_ok)
		|=> occ_q == $past(occ_q) + CW'(1))
		else $error("push did not grow the table");
`endif

endmodule

### tb/timestamped_pending_table_tb.sv
// ----------------------------------------------------------------------------
// timestamped_pending_table_tb: self-checking bench for the pending table
// Drives push, pop-by-key and expiry sweep transactions over the request
// channel, predicts every response with a local model of the age-ordered
// table and checks the response channel in order, under random idling on both
// sides and a long receiver stall that fills the block.
// ----------------------------------------------------------------------------
module timestamped_pending_table_tb;
	import tspt_pkg::*;

	// Opcode 3 has no name in the package; the block drops it silently.
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam int DEPTH          = TABLE_DEPTH_DEF;
	localparam int SWEEP_CAP      = MAX_SWEEP_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int HOLD_CYCLES    = 400;
	localparam int REPORT_LIMIT   = 10;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Local copy of the table: slot 0 is the oldest entry.
	entry_t held [DEPTH];
	int     held_cnt;

	// Responses the block still owes, oldest first.
	rsp_t due_rsp_q [$];

	// Idling knobs, in percent: per request for the sender, per cycle for the receiver.
	int   send_gap_pct;
	int   rsp_stall_pct;
	logic rsp_hold = 1'b0;

	// Stamp clock for well-formed traffic.
	logic [31:0] clock_sec;

	int error_cnt;
	int stall_cycles;
	int n_push, n_find, n_sweep, n_ignored, n_full, n_removed, n_checked;

	timestamped_pending_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Expected responses
	// ------------------------------------------------------------------------
	function automatic rsp_t status_only(input logic [1:0] status);
		rsp_t x;
		x = '0;
		x.status = status;
		x.last = 1'b1;
		return x;
	endfunction

	function automatic rsp_t removed_entry(input entry_t e, input logic last);
		rsp_t x;
		x = '0;
		x.entry_valid = 1'b1;
		x.out_key = e.key;
		x.out_sec = e.sec;
		x.out_nsec = e.nsec;
		x.status = STAT_OK;
		x.last = last;
		return x;
	endfunction

	// Apply one accepted transaction to the local table and queue the
	// responses it must produce.
	function automatic void apply_request(input req_t r);
		int i;
		int j;
		int wr;
		int taken;
		int cap;
		bit hit;
		rsp_t tail;
		case (r.opcode)
			OP_PUSH: begin
				n_push++;
				if (held_cnt >= DEPTH) begin
					// Full table: drop the entry, report it.
					n_full++;
					due_rsp_q.push_back(status_only(STAT_FULL));
				end else begin
					held[held_cnt] = '{key: r.key, sec: r.stamp_sec, nsec: r.stamp_nsec};
					held_cnt++;
					due_rsp_q.push_back(status_only(STAT_OK));
				end
			end
			OP_FIND: begin
				n_find++;
				hit = 1'b0;
				// Newest first; close the gap behind the first match.
				for (i = held_cnt - 1; i >= 0 && !hit; i--) begin
					if (held[i].key == r.key) begin
						hit = 1'b1;
						n_removed++;
						due_rsp_q.push_back(removed_entry(held[i], 1'b1));
						for (j = i; j + 1 < held_cnt; j++)
							held[j] = held[j + 1];
						held_cnt--;
					end
				end
				if (!hit)
					due_rsp_q.push_back(status_only(STAT_NOT_FOUND));
			end
			OP_SWEEP: begin
				n_sweep++;
				cap = (r.max_count > SWEEP_CAP) ? SWEEP_CAP : int'(r.max_count);
				wr = 0;
				taken = 0;
				// Oldest first; compact the survivors in place.
				for (i = 0; i < held_cnt; i++) begin
					if (taken < cap && (held[i].sec < r.stamp_sec ||
						(held[i].sec == r.stamp_sec && held[i].nsec <= r.stamp_nsec))) begin
						due_rsp_q.push_back(removed_entry(held[i], 1'b0));
						taken++;
					end else begin
						held[wr] = held[i];
						wr++;
					end
				end
				held_cnt = wr;
				n_removed += taken;
				if (taken == 0) begin
					due_rsp_q.push_back(status_only(STAT_OK));
				end else begin
					tail = due_rsp_q.pop_back();
					tail.last = 1'b1;
					due_rsp_q.push_back(tail);
				end
			end
			default: begin
				n_ignored++;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Response side: ready pattern and in-order check
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (due_rsp_q.size() == 0) begin
				error_cnt++;
				if (error_cnt <= REPORT_LIMIT)
					$display("ERROR: unexpected response v=%0b key=%h sec=%h nsec=%h st=%0d last=%0b",
						rsp.entry_valid, rsp.out_key, rsp.out_sec, rsp.out_nsec,
						rsp.status, rsp.last);
			end else begin
				want = due_rsp_q.pop_front();
				n_checked++;
				if (rsp.entry_valid !== want.entry_valid || rsp.out_key !== want.out_key ||
					rsp.out_sec !== want.out_sec || rsp.out_nsec !== want.out_nsec ||
					rsp.status !== want.status || rsp.last !== want.last) begin
					error_cnt++;
					if (error_cnt <= REPORT_LIMIT) begin
						$display("ERROR: response %0d mismatch", n_checked);
						$display("  expected v=%0b key=%h sec=%h nsec=%h st=%0d last=%0b",
							want.entry_valid, want.out_key, want.out_sec, want.out_nsec,
							want.status, want.last);
						$display("  actual   v=%0b key=%h sec=%h nsec=%h st=%0d last=%0b",
							rsp.entry_valid, rsp.out_key, rsp.out_sec, rsp.out_nsec,
							rsp.status, rsp.last);
					end
				end
			end
		end
	end

	// Watchdog: end the run if no transaction moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR: no transaction for %0d cycles, %0d responses outstanding",
				WATCHDOG_LIMIT, due_rsp_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	// Offer one transaction and return at the edge that takes it. Valid stays
	// high on return; the caller either offers the next one at once or drops
	// valid through a gap or a drain.
	task automatic send_req(input req_t r);
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		apply_request(r);
	endtask

	// Drop valid and hold off until every owed response has arrived.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (due_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// Hold the receiver off for a fixed stretch, counted here.
	task automatic hold_receiver(input int cycles);
		rsp_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		rsp_hold <= 1'b0;
	endtask

	function automatic req_t build_req(input logic [1:0] op, input logic [19:0] key,
		input logic [31:0] sec, input logic [29:0] nsec, input logic [4:0] cnt);
		req_t r;
		r.opcode = op;
		r.key = key;
		r.stamp_sec = sec;
		r.stamp_nsec = nsec;
		r.max_count = cnt;
		return r;
	endfunction

	// Nanoseconds biased toward a few values so equal stamps and the
	// nanosecond tie-break come up often; out-of-range values included.
	function automatic logic [29:0] pick_nsec();
		case ($urandom_range(7))
			0: return 30'd0;
			1: return 30'd999999999;
			2: return 30'h3FFFFFFF;
			3, 4: return 30'd500000000;
			5: return 30'($urandom_range(1000000000, 32'h3FFFFFFF));
			default: return 30'($urandom_range(999999999));
		endcase
	endfunction

	function automatic logic [19:0] pick_key();
		if ($urandom_range(3) == 0)
			return 20'($urandom);
		return 20'($urandom_range(11));
	endfunction

	// Mostly well-formed traffic around a slowly moving stamp clock, with a
	// little raw noise mixed in.
	function automatic req_t random_request();
		req_t r;
		int pick;
		pick = $urandom_range(99);
		if ($urandom_range(3) == 0)
			clock_sec = clock_sec + 32'd1;
		if (pick < 6) begin
			r.opcode = 2'($urandom);
			r.key = 20'($urandom);
			r.stamp_sec = $urandom;
			r.stamp_nsec = 30'($urandom);
			r.max_count = 5'($urandom);
		end else if (pick < 52) begin
			r = build_req(OP_PUSH, pick_key(), clock_sec + 32'($urandom_range(3)),
				pick_nsec(), 5'($urandom));
		end else if (pick < 76) begin
			r = build_req(OP_FIND, pick_key(), $urandom, 30'($urandom), 5'($urandom));
		end else begin
			r = build_req(OP_SWEEP, 20'($urandom), clock_sec + 32'($urandom_range(2)),
				pick_nsec(),
				($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4)));
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Empty-table cases, field extremes, a full table, newest-first lookup
	// and sweeps that exercise the count limit and the stamp tie-break.
	task automatic test_directed_corners();
		int i;
		logic [19:0] key;
		logic [31:0] sec;
		logic [29:0] nsec;
		send_gap_pct = 0;
		rsp_stall_pct = 0;
		// Nothing to expire, nothing to find, and an opcode the block drops.
		send_req(build_req(OP_SWEEP, 20'h0, 32'hFFFFFFFF, 30'd999999999, 5'd5));
		send_req(build_req(OP_FIND, 20'hFFFFF, 32'h0, 30'h0, 5'd0));
		send_req(build_req(OP_NONE, 20'hFFFFF, 32'hFFFFFFFF, 30'h3FFFFFFF, 5'h1F));
		// Fill every slot; entries pair up on the same second.
		for (i = 0; i < DEPTH; i++) begin
			if (i == 0)
				key = 20'h0;
			else if (i == 1)
				key = 20'hFFFFF;
			else if (i % 4 == 2)
				key = 20'h000A5;
			else
				key = 20'(i);
			if (i == 0)
				sec = 32'h0;
			else if (i == 1)
				sec = 32'hFFFFFFFF;
			else
				sec = 32'(1000 + i / 2);
			if (i == 0)
				nsec = 30'h0;
			else if (i == 1)
				nsec = 30'h3FFFFFFF;
			else if (i % 2 == 1)
				nsec = 30'd999999999;
			else
				nsec = 30'(i * 1000);
			send_req(build_req(OP_PUSH, key, sec, nsec, 5'h1F));
		end
		// Push into a full table, then a lookup with a duplicated key and one that misses.
		send_req(build_req(OP_PUSH, 20'h12345, 32'd5, 30'd5, 5'd0));
		send_req(build_req(OP_FIND, 20'h000A5, 32'h0, 30'h0, 5'd0));
		send_req(build_req(OP_FIND, 20'h54321, 32'h0, 30'h0, 5'd0));
		// Zero count, a cutoff inside one second, then a saturating count and a count of one.
		send_req(build_req(OP_SWEEP, 20'h0, 32'hFFFFFFFF, 30'h3FFFFFFF, 5'd0));
		send_req(build_req(OP_SWEEP, 20'h0, 32'd1004, 30'd4000, 5'h1F));
		send_req(build_req(OP_SWEEP, 20'h0, 32'hFFFFFFFF, 30'd999999999, 5'd17));
		send_req(build_req(OP_SWEEP, 20'h0, 32'hFFFFFFFF, 30'h3FFFFFFF, 5'd1));
		wait_for_drain();
	endtask

	// Random traffic under one idling pattern; dropped opcodes do not count.
	task automatic test_random_mix(input int gap_pct, input int stall_pct, input int items);
		int counted;
		req_t r;
		send_gap_pct = gap_pct;
		rsp_stall_pct = stall_pct;
		counted = 0;
		while (counted < items) begin
			r = random_request();
			send_req(r);
			if (r.opcode != OP_NONE)
				counted++;
		end
	endtask

	// Stall the receiver for a long stretch while requests keep coming, so
	// the output register fills and the block stops taking requests.
	task automatic test_backpressure_fill();
		int i;
		send_gap_pct = 0;
		rsp_stall_pct = 0;
		fork
			hold_receiver(HOLD_CYCLES);
		join_none
		for (i = 0; i < 30; i++)
			send_req(random_request());
		wait_for_drain();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		held_cnt = 0;
		error_cnt = 0;
		stall_cycles = 0;
		send_gap_pct = 0;
		rsp_stall_pct = 0;
		clock_sec = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_mix(6, 62, 80);
		test_random_mix(62, 6, 80);
		test_random_mix(0, 0, 80);
		test_backpressure_fill();

		// Let any late or stray response surface before judging.
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d pushes (%0d on a full table), %0d key lookups, %0d sweeps,",
			n_push, n_full, n_find, n_sweep);
		$display("%0d dropped opcodes; %0d entries removed, %0d responses checked, %0d errors.",
			n_ignored, n_removed, n_checked, error_cnt + due_rsp_q.size());
		if (error_cnt == 0 && due_rsp_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
